@@ hdl/ppfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfs_pkg
// Shared types and constants of the pump pressure fault supervisor.
// ----------------------------------------------------------------------------
package ppfs_pkg;

  // debounce length of the analog limits, and settling ticks after stop entry
  localparam int DEBOUNCE_TICKS  = 3;
  localparam int STOP_WAIT_TICKS = 1;

  localparam logic [3:0]  CNT_MAX         = 4'hF;
  localparam logic [15:0] LOW_PRESS_FLOOR = 16'd20;
  localparam int          DRIVE_SW_FAULT_BIT = 3;

  // pump states
  localparam logic [2:0] ST_STOP    = 3'd0;
  localparam logic [2:0] ST_PRESS   = 3'd1;
  localparam logic [2:0] ST_HOLD    = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_SETTING = 3'd4;
  localparam logic [2:0] ST_FAULT   = 3'd5;
  localparam logic [2:0] ST_NONE    = 3'd7;

  // motor commands
  localparam logic [1:0] MC_STOP  = 2'd0;
  localparam logic [1:0] MC_RUN   = 2'd1;
  localparam logic [1:0] MC_FAULT = 2'd2;
  localparam logic [1:0] MC_WAIT  = 2'd3;

  // fault bitmap positions
  localparam int FB_PSENS     = 0;
  localparam int FB_TSENS     = 1;
  localparam int FB_LSENS     = 2;
  localparam int FB_OVERPRESS = 3;
  localparam int FB_OVERHEAT  = 4;
  localparam int FB_LOWLEVEL  = 5;
  localparam int FB_LINK      = 6;
  localparam int FB_DRIVE     = 7;

  // register indexes
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_MAXP     = 3'd1;
  localparam logic [2:0] REG_HYST     = 3'd2;
  localparam logic [2:0] REG_SEVERE   = 3'd3;
  localparam logic [2:0] REG_OIL_TEMP = 3'd4;
  localparam logic [2:0] REG_MIN_LVL  = 3'd5;

  typedef struct packed {
    logic [15:0]        pressure;
    logic signed [11:0] oil_temp;
    logic [9:0]         liquid_level;
    logic               press_sensor_err;
    logic               temp_sensor_err;
    logic               level_sensor_err;
    logic               motor_link_lost;
    logic [15:0]        drive_error_code;
    logic [15:0]        drive_status_word;
    logic               mode_not_velocity;
    logic               reset_request;
    logic               setting_hold;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pump_state;
    logic       valve_open;
    logic [1:0] motor_command;
    logic [7:0] fault_bitmap;
    logic       sensors_ready;
    logic       reset_rejected;
  } out_item_t;

endpackage

@@ hdl/ppfs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfs_in_if / ppfs_out_if
// Valid/ready channels for supervision ticks and their results.
// ----------------------------------------------------------------------------
interface ppfs_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        pressure;
  logic signed [11:0] oil_temp;
  logic [9:0]         liquid_level;
  logic               press_sensor_err;
  logic               temp_sensor_err;
  logic               level_sensor_err;
  logic               motor_link_lost;
  logic [15:0]        drive_error_code;
  logic [15:0]        drive_status_word;
  logic               mode_not_velocity;
  logic               reset_request;
  logic               setting_hold;

  modport source (
    output valid, pressure, oil_temp, liquid_level, press_sensor_err,
           temp_sensor_err, level_sensor_err, motor_link_lost, drive_error_code,
           drive_status_word, mode_not_velocity, reset_request, setting_hold,
    input  ready
  );
  modport sink (
    input  valid, pressure, oil_temp, liquid_level, press_sensor_err,
           temp_sensor_err, level_sensor_err, motor_link_lost, drive_error_code,
           drive_status_word, mode_not_velocity, reset_request, setting_hold,
    output ready
  );
endinterface

interface ppfs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] pump_state;
  logic       valve_open;
  logic [1:0] motor_command;
  logic [7:0] fault_bitmap;
  logic       sensors_ready;
  logic       reset_rejected;

  modport source (
    output valid, pump_state, valve_open, motor_command, fault_bitmap,
           sensors_ready, reset_rejected,
    input  ready
  );
  modport sink (
    input  valid, pump_state, valve_open, motor_command, fault_bitmap,
           sensors_ready, reset_rejected,
    output ready
  );
endinterface

@@ hdl/pump_pressure_fault_supervisor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_pressure_fault_supervisor_top
// Debounced limit checks, fault bitmap and pump state machine per tick.
// ----------------------------------------------------------------------------
// usage
//   in_if   : one supervision tick per item (readings, sensor/link/drive flags,
//             operator reset and setting-hold levels)
//   out_if  : one result item per tick: pump state, valve and motor commands,
//             fault bitmap, sensors-ready and reset-rejected flags
//   cfg_*   : apb-style write/read of the six limits, register i at 4*i,
//             pready tied high; write only while no item is in flight
//   path    : input accept goes to the input register, then one pass of
//             compare/update logic into the result register
//   rate    : one item per cycle while out_if.ready is high; the only loop is
//             the state registers fed back into the combinational update logic
//   stall   : while out_if.ready is low the result holds, one more item can
//             wait in the input register, then in_if.ready drops
//   reset   : rst_n low clears both stages, limits return to their defaults,
//             state goes to stop with entry actions pending
// ----------------------------------------------------------------------------
module pump_pressure_fault_supervisor_top
  import ppfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ppfs_in_if.sink               in_if,
  ppfs_out_if.source            out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  // configuration registers
  logic [15:0]        target_r, maxp_r, hyst_r, severe_r;
  logic signed [11:0] oil_lim_r;
  logic [9:0]         min_lvl_r;

  // pipeline registers
  logic      s1_valid_r, out_valid_r;
  in_item_t  s1_r;
  out_item_t out_r, out_nxt;

  // supervisor state
  logic [2:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [1:0] motor_r, motor_nxt;
  logic       valve_r, valve_nxt;
  logic [3:0] op_cnt_r, op_cnt_nxt, oh_cnt_r, oh_cnt_nxt, ll_cnt_r, ll_cnt_nxt;
  logic       sev_r, sev_nxt;
  logic       rreq_prev_r;
  logic [3:0] wait_r, wait_nxt;

  logic adv, work, cfg_wr;

  // ------------------------------------------------------------------
  // handshake: result register frees when taken, input stage follows
  // ------------------------------------------------------------------
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || adv;
  assign work        = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_r.pressure          <= in_if.pressure;
      s1_r.oil_temp          <= in_if.oil_temp;
      s1_r.liquid_level      <= in_if.liquid_level;
      s1_r.press_sensor_err  <= in_if.press_sensor_err;
      s1_r.temp_sensor_err   <= in_if.temp_sensor_err;
      s1_r.level_sensor_err  <= in_if.level_sensor_err;
      s1_r.motor_link_lost   <= in_if.motor_link_lost;
      s1_r.drive_error_code  <= in_if.drive_error_code;
      s1_r.drive_status_word <= in_if.drive_status_word;
      s1_r.mode_not_velocity <= in_if.mode_not_velocity;
      s1_r.reset_request     <= in_if.reset_request;
      s1_r.setting_hold      <= in_if.setting_hold;
    end
    if (work) out_r <= out_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.pump_state     = out_r.pump_state;
  assign out_if.valve_open     = out_r.valve_open;
  assign out_if.motor_command  = out_r.motor_command;
  assign out_if.fault_bitmap   = out_r.fault_bitmap;
  assign out_if.sensors_ready  = out_r.sensors_ready;
  assign out_if.reset_rejected = out_r.reset_rejected;

  // ------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= 16'd500;
      maxp_r    <= 16'd2000;
      hyst_r    <= 16'd30;
      severe_r  <= 16'd2200;
      oil_lim_r <= 12'sd850;
      min_lvl_r <= 10'd200;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_TARGET:   target_r  <= cfg_pwdata[15:0];
        REG_MAXP:     maxp_r    <= cfg_pwdata[15:0];
        REG_HYST:     hyst_r    <= cfg_pwdata[15:0];
        REG_SEVERE:   severe_r  <= cfg_pwdata[15:0];
        REG_OIL_TEMP: oil_lim_r <= $signed(cfg_pwdata[11:0]);
        REG_MIN_LVL:  min_lvl_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_TARGET:   cfg_prdata = {16'd0, target_r};
      REG_MAXP:     cfg_prdata = {16'd0, maxp_r};
      REG_HYST:     cfg_prdata = {16'd0, hyst_r};
      REG_SEVERE:   cfg_prdata = {16'd0, severe_r};
      REG_OIL_TEMP: cfg_prdata = {{20{oil_lim_r[11]}}, oil_lim_r};
      REG_MIN_LVL:  cfg_prdata = {22'd0, min_lvl_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // one tick of supervision
  // ------------------------------------------------------------------
  logic       trig, op_cond, oh_cond, ll_cond;
  logic       op_hit, oh_hit, ll_hit;
  logic       drive_fault, mode_bad, auto_f, lock_f, any_f, entry;
  logic       below_band, at_max, at_tgt, above_floor;
  logic       temp_hot, level_low_eq, rejected;
  logic [7:0] bits;
  logic [2:0] st_a, st_b;

  function automatic logic [3:0] sat_inc(input logic [3:0] c);
    return (c == CNT_MAX) ? CNT_MAX : c + 4'd1;
  endfunction

  always_comb begin
    trig = s1_r.reset_request && !rreq_prev_r;

    // debounced analog limits
    temp_hot     = s1_r.oil_temp >= oil_lim_r;
    level_low_eq = s1_r.liquid_level <= min_lvl_r;
    op_cond      = s1_r.pressure >= severe_r;
    oh_cond      = temp_hot;
    ll_cond      = !s1_r.level_sensor_err && (s1_r.liquid_level < min_lvl_r);

    op_cnt_nxt = op_cond ? sat_inc(op_cnt_r) : 4'd0;
    oh_cnt_nxt = oh_cond ? sat_inc(oh_cnt_r) : 4'd0;
    ll_cnt_nxt = ll_cond ? sat_inc(ll_cnt_r) : 4'd0;
    op_hit = op_cond && (op_cnt_nxt >= 4'(DEBOUNCE_TICKS));
    oh_hit = oh_cond && (oh_cnt_nxt >= 4'(DEBOUNCE_TICKS));
    ll_hit = ll_cond && (ll_cnt_nxt >= 4'(DEBOUNCE_TICKS));
    sev_nxt = op_cond ? (op_hit || sev_r) : 1'b0;

    // link loss masks the drive checks
    mode_bad    = !s1_r.motor_link_lost && s1_r.mode_not_velocity;
    drive_fault = !s1_r.motor_link_lost &&
                  ((s1_r.drive_error_code != 16'd0) ||
                   s1_r.drive_status_word[DRIVE_SW_FAULT_BIT]);

    bits = 8'd0;
    bits[FB_PSENS]     = s1_r.press_sensor_err;
    bits[FB_TSENS]     = s1_r.temp_sensor_err;
    bits[FB_LSENS]     = s1_r.level_sensor_err;
    bits[FB_OVERPRESS] = op_hit;
    bits[FB_OVERHEAT]  = oh_hit;
    bits[FB_LOWLEVEL]  = ll_hit;
    bits[FB_LINK]      = s1_r.motor_link_lost;
    bits[FB_DRIVE]     = drive_fault;

    auto_f = drive_fault || s1_r.motor_link_lost || sev_nxt || mode_bad ||
             s1_r.press_sensor_err || s1_r.temp_sensor_err || s1_r.level_sensor_err;
    lock_f = oh_hit || ll_hit;
    any_f  = auto_f || lock_f;

    // pressure compares; band test as p + hyst < target avoids a signed band
    below_band  = ({1'b0, s1_r.pressure} + {1'b0, hyst_r}) < {1'b0, target_r};
    at_max      = s1_r.pressure >= maxp_r;
    at_tgt      = s1_r.pressure >= target_r;
    above_floor = s1_r.pressure > LOW_PRESS_FLOOR;

    // forced states: setting hold first, then fault
    if (s1_r.setting_hold)        st_a = ST_SETTING;
    else if (cur_r == ST_SETTING) st_a = ST_STOP;
    else                          st_a = cur_r;
    if (any_f && (st_a != ST_SETTING) && (st_a != ST_FAULT)) st_b = ST_FAULT;
    else                                                     st_b = st_a;

    entry    = prev_r != st_b;
    prev_nxt = st_b;

    cur_nxt   = st_b;
    motor_nxt = motor_r;
    valve_nxt = valve_r;
    wait_nxt  = wait_r;
    rejected  = 1'b0;

    unique case (st_b)
      ST_SETTING: begin
        if (entry && motor_nxt != MC_FAULT) motor_nxt = MC_STOP;
        if (any_f) motor_nxt = MC_STOP;
      end
      ST_STOP: begin
        if (entry) begin
          wait_nxt  = 4'd0;
          valve_nxt = 1'b0;
          if (motor_nxt != MC_FAULT) motor_nxt = MC_STOP;
        end
        // settle before any pressure decision
        if (wait_nxt < 4'(STOP_WAIT_TICKS)) begin
          wait_nxt = wait_nxt + 4'd1;
        end else begin
          if (below_band && above_floor) cur_nxt = ST_PRESS;
          if (at_max) cur_nxt = ST_RELEASE;
        end
      end
      ST_PRESS: begin
        if (entry) motor_nxt = MC_RUN;
        if (at_tgt) cur_nxt = ST_HOLD;
        if (at_max) cur_nxt = ST_STOP;
      end
      ST_HOLD: begin
        if (entry) motor_nxt = MC_RUN;
        if (below_band) cur_nxt = ST_PRESS;
        if (at_max) cur_nxt = ST_STOP;
      end
      ST_RELEASE: begin
        if (entry) begin
          valve_nxt = 1'b1;
          if (motor_nxt != MC_FAULT) motor_nxt = MC_STOP;
        end
        if (!above_floor) begin
          valve_nxt = 1'b0;
          cur_nxt   = ST_STOP;
        end
      end
      default: begin
        // fault: auto clear, then the manual re-check on a reset edge
        if (entry) motor_nxt = MC_FAULT;
        valve_nxt = sev_nxt;
        if (!any_f) begin
          cur_nxt   = ST_STOP;
          motor_nxt = MC_WAIT;
        end
        if (trig) begin
          if (temp_hot || level_low_eq) begin
            rejected = 1'b1;
          end else begin
            cur_nxt   = ST_STOP;
            motor_nxt = MC_WAIT;
          end
        end
      end
    endcase

    out_nxt.pump_state     = cur_nxt;
    out_nxt.valve_open     = valve_nxt;
    out_nxt.motor_command  = motor_nxt;
    out_nxt.fault_bitmap   = bits;
    out_nxt.sensors_ready  = (bits[FB_LSENS:FB_PSENS] == 3'd0);
    out_nxt.reset_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= ST_STOP;
      prev_r      <= ST_NONE;
      motor_r     <= MC_STOP;
      valve_r     <= 1'b0;
      op_cnt_r    <= 4'd0;
      oh_cnt_r    <= 4'd0;
      ll_cnt_r    <= 4'd0;
      sev_r       <= 1'b0;
      rreq_prev_r <= 1'b0;
      wait_r      <= 4'd0;
    end else if (work) begin
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      motor_r     <= motor_nxt;
      valve_r     <= valve_nxt;
      op_cnt_r    <= op_cnt_nxt;
      oh_cnt_r    <= oh_cnt_nxt;
      ll_cnt_r    <= ll_cnt_nxt;
      sev_r       <= sev_nxt;
      rreq_prev_r <= s1_r.reset_request;
      wait_r      <= wait_nxt;
    end
  end

endmodule

@@ hdl/ppfs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfs_checker
// Port-level checks of the supervisor result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppfs_checker
  import ppfs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] pump_state,
  input logic       valve_open,
  input logic [1:0] motor_command,
  input logic [7:0] fault_bitmap,
  input logic       sensors_ready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pump_state) &&
    $stable(motor_command) && $stable(fault_bitmap) && $stable(valve_open))
    else $error("stalled result changed");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // severe overpressure in fault state opens the relief valve
  a_fault_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pump_state == ST_FAULT && fault_bitmap[FB_OVERPRESS] |-> valve_open)
    else $error("severe overpressure in fault with valve closed");

  // sensors ready agrees with the sensor bits
  a_sens_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sensors_ready == (fault_bitmap[FB_LSENS:FB_PSENS] == 3'd0))
    else $error("sensors ready disagrees with bitmap");

endmodule

bind pump_pressure_fault_supervisor_top ppfs_checker u_ppfs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .pump_state    (out_if.pump_state),
  .valve_open    (out_if.valve_open),
  .motor_command (out_if.motor_command),
  .fault_bitmap  (out_if.fault_bitmap),
  .sensors_ready (out_if.sensors_ready)
);

@@ tb/sv/ppfs_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfs_result_checker
// Watches the tick, result and register channels of the pump supervisor,
// predicts each result from its own copy of limits and state, and compares.
// ----------------------------------------------------------------------------
module ppfs_result_checker
  import ppfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ppfs_in_if                    tick_ch,
  ppfs_out_if                   status_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    pending
);

  // limits as the block should hold them
  int lim_target, lim_maxp, lim_hyst, lim_severe, lim_oil, lim_level;

  // supervisor state
  logic [2:0] pump_st, last_st;
  logic [1:0] motor_q;
  logic       valve_q, severe_q, rreq_q;
  logic [3:0] over_cnt, heat_cnt, low_cnt, settle_cnt;

  out_item_t predicted_status[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [3:0] bump(input logic [3:0] c);
    return (c < CNT_MAX) ? c + 4'd1 : CNT_MAX;
  endfunction

  task automatic supervise_tick(input in_item_t t, output out_item_t r);
    int         p, temp, lvl, band;
    logic [7:0] bits;
    bit         trig, oil_f, low_f, drv_f, mode_f, auto_f, lock_f, entry, rejected;
    p        = t.pressure;
    temp     = $signed(t.oil_temp);
    lvl      = t.liquid_level;
    band     = lim_target - lim_hyst;
    trig     = t.reset_request && !rreq_q;
    rreq_q   = t.reset_request;
    bits     = '0;
    oil_f    = 0;
    low_f    = 0;
    drv_f    = 0;
    mode_f   = 0;
    rejected = 0;
    bits[FB_PSENS] = t.press_sensor_err;
    bits[FB_TSENS] = t.temp_sensor_err;
    bits[FB_LSENS] = t.level_sensor_err;

    // debounced limits
    if (p >= lim_severe) begin
      over_cnt = bump(over_cnt);
      if (over_cnt >= DEBOUNCE_TICKS) begin
        severe_q = 1'b1;
        bits[FB_OVERPRESS] = 1'b1;
      end
    end else begin
      over_cnt = '0;
      severe_q = 1'b0;
    end
    if (temp >= lim_oil) begin
      heat_cnt = bump(heat_cnt);
      if (heat_cnt >= DEBOUNCE_TICKS) begin
        oil_f = 1;
        bits[FB_OVERHEAT] = 1'b1;
      end
    end else begin
      heat_cnt = '0;
    end
    if (!t.level_sensor_err && lvl < lim_level) begin
      low_cnt = bump(low_cnt);
      if (low_cnt >= DEBOUNCE_TICKS) begin
        low_f = 1;
        bits[FB_LOWLEVEL] = 1'b1;
      end
    end else begin
      low_cnt = '0;
    end

    // a lost link hides the drive checks
    if (t.motor_link_lost) begin
      bits[FB_LINK] = 1'b1;
    end else begin
      mode_f = t.mode_not_velocity;
      if (t.drive_error_code != 0 || t.drive_status_word[DRIVE_SW_FAULT_BIT]) begin
        drv_f = 1;
        bits[FB_DRIVE] = 1'b1;
      end
    end

    auto_f = drv_f || t.motor_link_lost || severe_q || mode_f || t.press_sensor_err ||
             t.temp_sensor_err || t.level_sensor_err;
    lock_f = oil_f || low_f;

    if (t.setting_hold) pump_st = ST_SETTING;
    else if (pump_st == ST_SETTING) pump_st = ST_STOP;
    if ((auto_f || lock_f) && pump_st != ST_SETTING && pump_st != ST_FAULT) pump_st = ST_FAULT;

    entry   = last_st != pump_st;
    last_st = pump_st;

    case (pump_st)
      ST_SETTING: begin
        if (entry && motor_q != MC_FAULT) motor_q = MC_STOP;
        if (auto_f || lock_f) motor_q = MC_STOP;
      end
      ST_STOP: begin
        if (entry) begin
          settle_cnt = '0;
          valve_q    = 1'b0;
          if (motor_q != MC_FAULT) motor_q = MC_STOP;
        end
        if (settle_cnt < STOP_WAIT_TICKS) begin
          settle_cnt = settle_cnt + 4'd1;
        end else begin
          if (p < band && p > int'(LOW_PRESS_FLOOR)) pump_st = ST_PRESS;
          if (p >= lim_maxp) pump_st = ST_RELEASE;
        end
      end
      ST_PRESS: begin
        if (entry) motor_q = MC_RUN;
        if (p >= lim_target) pump_st = ST_HOLD;
        if (p >= lim_maxp) pump_st = ST_STOP;
      end
      ST_HOLD: begin
        if (entry) motor_q = MC_RUN;
        if (p < band) pump_st = ST_PRESS;
        if (p >= lim_maxp) pump_st = ST_STOP;
      end
      ST_RELEASE: begin
        if (entry) begin
          valve_q = 1'b1;
          if (motor_q != MC_FAULT) motor_q = MC_STOP;
        end
        if (p <= int'(LOW_PRESS_FLOOR)) begin
          valve_q = 1'b0;
          pump_st = ST_STOP;
        end
      end
      default: begin
        if (entry) motor_q = MC_FAULT;
        valve_q = severe_q;
        if (!lock_f && !auto_f) begin
          pump_st = ST_STOP;
          motor_q = MC_WAIT;
        end
        // manual re-check runs even after the auto clear above
        if (trig) begin
          if (temp >= lim_oil || lvl <= lim_level) begin
            rejected = 1;
          end else begin
            pump_st = ST_STOP;
            motor_q = MC_WAIT;
          end
        end
      end
    endcase

    r.pump_state     = pump_st;
    r.valve_open     = valve_q;
    r.motor_command  = motor_q;
    r.fault_bitmap   = bits;
    r.sensors_ready  = (bits[2:0] == 3'b000);
    r.reset_rejected = rejected;
  endtask

  always @(posedge clk) begin
    in_item_t  tick;
    out_item_t seen, want;
    if (!rst_n) begin
      fail_count = 0;
      lim_target = 500;
      lim_maxp   = 2000;
      lim_hyst   = 30;
      lim_severe = 2200;
      lim_oil    = 850;
      lim_level  = 200;
      pump_st    = ST_STOP;
      last_st    = ST_NONE;
      motor_q    = MC_STOP;
      valve_q    = 1'b0;
      severe_q   = 1'b0;
      rreq_q     = 1'b0;
      over_cnt   = '0;
      heat_cnt   = '0;
      low_cnt    = '0;
      settle_cnt = '0;
      predicted_status.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_TARGET:   lim_target = cfg_pwdata[15:0];
          REG_MAXP:     lim_maxp   = cfg_pwdata[15:0];
          REG_HYST:     lim_hyst   = cfg_pwdata[15:0];
          REG_SEVERE:   lim_severe = cfg_pwdata[15:0];
          REG_OIL_TEMP: lim_oil    = $signed(cfg_pwdata[11:0]);
          REG_MIN_LVL:  lim_level  = cfg_pwdata[9:0];
          default: ;
        endcase
      end

      if (status_ch.valid && status_ch.ready) begin
        seen.pump_state     = status_ch.pump_state;
        seen.valve_open     = status_ch.valve_open;
        seen.motor_command  = status_ch.motor_command;
        seen.fault_bitmap   = status_ch.fault_bitmap;
        seen.sensors_ready  = status_ch.sensors_ready;
        seen.reset_rejected = status_ch.reset_rejected;
        if (predicted_status.size() == 0) begin
          report_mismatch("unexpected result, pump_state", seen.pump_state, -1);
        end else begin
          want = predicted_status.pop_front();
          if (seen.pump_state !== want.pump_state)
            report_mismatch("pump_state", seen.pump_state, want.pump_state);
          if (seen.valve_open !== want.valve_open)
            report_mismatch("valve_open", seen.valve_open, want.valve_open);
          if (seen.motor_command !== want.motor_command)
            report_mismatch("motor_command", seen.motor_command, want.motor_command);
          if (seen.fault_bitmap !== want.fault_bitmap)
            report_mismatch("fault_bitmap", seen.fault_bitmap, want.fault_bitmap);
          if (seen.sensors_ready !== want.sensors_ready)
            report_mismatch("sensors_ready", seen.sensors_ready, want.sensors_ready);
          if (seen.reset_rejected !== want.reset_rejected)
            report_mismatch("reset_rejected", seen.reset_rejected, want.reset_rejected);
        end
      end

      if (tick_ch.valid && tick_ch.ready) begin
        tick.pressure          = tick_ch.pressure;
        tick.oil_temp          = tick_ch.oil_temp;
        tick.liquid_level      = tick_ch.liquid_level;
        tick.press_sensor_err  = tick_ch.press_sensor_err;
        tick.temp_sensor_err   = tick_ch.temp_sensor_err;
        tick.level_sensor_err  = tick_ch.level_sensor_err;
        tick.motor_link_lost   = tick_ch.motor_link_lost;
        tick.drive_error_code  = tick_ch.drive_error_code;
        tick.drive_status_word = tick_ch.drive_status_word;
        tick.mode_not_velocity = tick_ch.mode_not_velocity;
        tick.reset_request     = tick_ch.reset_request;
        tick.setting_hold      = tick_ch.setting_hold;
        supervise_tick(tick, want);
        predicted_status.push_back(want);
      end
    end
    pending = predicted_status.size();
  end

endmodule

@@ tb/sv/tb_pump_pressure_fault_supervisor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pump_pressure_fault_supervisor_top
// Drives supervision ticks and limit writes into the pump supervisor, stalls
// the result side, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_pump_pressure_fault_supervisor_top;
  import ppfs_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending;

  // shadow of the limits, only used to steer stimulus into interesting bands
  int sh_target, sh_maxp, sh_hyst, sh_severe, sh_oil, sh_level;

  // random-walk state of the tick generator
  int walk_p;
  int severe_left, hot_left, low_left, setting_left;
  bit rreq_lvl;

  // asks the result side for one long hold-off
  bit hold_off_go;

  ppfs_in_if  tick_ch();
  ppfs_out_if status_ch();

  always #5 clk = ~clk;

  pump_pressure_fault_supervisor_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (tick_ch),
    .out_if      (status_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ppfs_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_ch     (tick_ch),
    .status_ch   (status_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // quiet tick: no sensor, link or drive trouble, operator levels low
  function automatic in_item_t base_tick(input int p, input int temp, input int lvl);
    in_item_t t;
    t              = '0;
    t.pressure     = p[15:0];
    t.oil_temp     = temp[11:0];
    t.liquid_level = lvl[9:0];
    return t;
  endfunction

  // mostly healthy ticks with pressure wandering through the control bands,
  // plus fault episodes, some long enough to pass (and saturate) the debounce
  function automatic in_item_t next_tick();
    in_item_t t;
    int       temp, lvl;
    t = '0;

    case ($urandom_range(0, 15))
      0: walk_p = $urandom_range(0, 65535);
      1: walk_p = $urandom_range(0, 25);
      2: walk_p = sh_target - sh_hyst + int'($urandom_range(0, 6)) - 3;
      3: walk_p = sh_target + int'($urandom_range(0, 6)) - 3;
      4: walk_p = sh_maxp + int'($urandom_range(0, 6)) - 3;
      5: walk_p = sh_severe + int'($urandom_range(0, 6)) - 3;
      6: if (severe_left == 0) severe_left = $urandom_range(1, 6);
      default: walk_p = walk_p + int'($urandom_range(0, 120)) - 60;
    endcase
    if (severe_left > 0) begin
      severe_left--;
      walk_p = sh_severe + int'($urandom_range(0, 50));
    end
    walk_p     = clip(walk_p, 0, 65535);
    t.pressure = walk_p[15:0];

    // oil temperature: overheat episodes, one below the limit, and full range noise
    if (hot_left == 0 && $urandom_range(0, 39) == 0) hot_left = $urandom_range(1, 20);
    if (hot_left > 0) begin
      hot_left--;
      temp = sh_oil + int'($urandom_range(0, 40));
    end else begin
      case ($urandom_range(0, 19))
        0:       temp = int'($urandom_range(0, 4095)) - 2048;
        1:       temp = sh_oil - 1;
        default: temp = sh_oil - int'($urandom_range(1, 600));
      endcase
    end
    t.oil_temp = 12'(clip(temp, -2048, 2047));

    // liquid level: low episodes, the exact limit, and full range noise
    if (low_left == 0 && $urandom_range(0, 39) == 0) low_left = $urandom_range(1, 20);
    if (low_left > 0) begin
      low_left--;
      lvl = sh_level - int'($urandom_range(1, 50));
    end else begin
      case ($urandom_range(0, 19))
        0:       lvl = $urandom_range(0, 1023);
        1:       lvl = sh_level;
        default: lvl = sh_level + int'($urandom_range(1, 400));
      endcase
    end
    t.liquid_level = 10'(clip(lvl, 0, 1023));

    t.press_sensor_err  = ($urandom_range(0, 49) == 0);
    t.temp_sensor_err   = ($urandom_range(0, 49) == 0);
    t.level_sensor_err  = ($urandom_range(0, 49) == 0);
    t.motor_link_lost   = ($urandom_range(0, 49) == 0);
    t.mode_not_velocity = ($urandom_range(0, 39) == 0);
    t.drive_error_code  = ($urandom_range(0, 29) == 0) ? 16'($urandom) : 16'h0000;
    t.drive_status_word = 16'($urandom);
    if ($urandom_range(0, 29) != 0) t.drive_status_word[DRIVE_SW_FAULT_BIT] = 1'b0;

    // operator reset is a level, so toggle it now and then to make edges
    if ($urandom_range(0, 5) == 0) rreq_lvl = !rreq_lvl;
    t.reset_request = rreq_lvl;

    if (setting_left == 0 && $urandom_range(0, 59) == 0) setting_left = $urandom_range(1, 8);
    if (setting_left > 0) begin
      setting_left--;
      t.setting_hold = 1'b1;
    end
    return t;
  endfunction

  task automatic put_tick(input in_item_t t);
    tick_ch.pressure          = t.pressure;
    tick_ch.oil_temp          = t.oil_temp;
    tick_ch.liquid_level      = t.liquid_level;
    tick_ch.press_sensor_err  = t.press_sensor_err;
    tick_ch.temp_sensor_err   = t.temp_sensor_err;
    tick_ch.level_sensor_err  = t.level_sensor_err;
    tick_ch.motor_link_lost   = t.motor_link_lost;
    tick_ch.drive_error_code  = t.drive_error_code;
    tick_ch.drive_status_word = t.drive_status_word;
    tick_ch.mode_not_velocity = t.mode_not_velocity;
    tick_ch.reset_request     = t.reset_request;
    tick_ch.setting_hold      = t.setting_hold;
  endtask

  // called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with valid still high for a following item
  task automatic send_tick(input in_item_t t);
    bit took;
    put_tick(t);
    tick_ch.valid = 1'b1;
    do begin
      @(posedge clk);
      took = tick_ch.ready;
      @(negedge clk);
    end while (!took);
  endtask

  task automatic idle_for(input int n);
    tick_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_drained();
    tick_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup phase, then access phase until pready
  task automatic write_reg(input logic [2:0] idx, input int value);
    bit done;
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do begin
      @(posedge clk);
      done = cfg_pready;
      @(negedge clk);
    end while (!done);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic set_limits(input int tgt, input int maxp, input int hyst, input int sev,
                            input int oil, input int lvl);
    wait_drained();
    write_reg(REG_TARGET, tgt);
    write_reg(REG_MAXP, maxp);
    write_reg(REG_HYST, hyst);
    write_reg(REG_SEVERE, sev);
    write_reg(REG_OIL_TEMP, oil);
    write_reg(REG_MIN_LVL, lvl);
    sh_target = tgt;
    sh_maxp   = maxp;
    sh_hyst   = hyst;
    sh_severe = sev;
    sh_oil    = oil;
    sh_level  = lvl;
  endtask

  // result side: stall pattern switches between random modes, and once
  // holds off for a long stretch so the block backs up into its input
  initial begin : result_sink
    int stall_left, mode, mode_left, beat;
    bit held_once;
    status_ch.ready = 1'b0;
    stall_left      = 0;
    mode            = 0;
    mode_left       = 0;
    beat            = 0;
    held_once       = 0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !held_once) begin
        held_once  = 1;
        stall_left = 60;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      beat++;
      if (stall_left > 0) begin
        stall_left--;
        status_ch.ready = 1'b0;
      end else begin
        case (mode)
          0:       status_ch.ready = 1'b1;
          1:       status_ch.ready = ($urandom_range(0, 9) < 7);
          2:       status_ch.ready = ($urandom_range(0, 9) < 3);
          default: status_ch.ready = (beat % 3 != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    in_item_t t;
    int       ph, k, n, burst_left, waited;

    // every input known from time zero while reset is held
    rst_n         = 1'b0;
    tick_ch.valid = 1'b0;
    put_tick('0);
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    hold_off_go   = 0;
    sh_target     = 500;
    sh_maxp       = 2000;
    sh_hyst       = 30;
    sh_severe     = 2200;
    sh_oil        = 850;
    sh_level      = 200;
    walk_p        = 400;
    severe_left   = 0;
    hot_left      = 0;
    low_left      = 0;
    setting_left  = 0;
    rreq_lvl      = 0;
    burst_left    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed walk through the state machine at the reset limits
    // coldest oil, empty tank: entry into stop, settling tick
    send_tick(base_tick(0, -2048, 0));
    // every bit high: setting hold wins over all the faults
    send_tick('1);
    send_tick(base_tick(0, 200, 500));
    send_tick(base_tick(300, 200, 500));   // below band: press
    send_tick(base_tick(500, 200, 500));   // at target: hold
    send_tick(base_tick(460, 200, 500));   // below band again: press
    send_tick(base_tick(2000, 200, 500));  // at max: stop
    send_tick(base_tick(2000, 200, 500));  // settling tick in stop
    send_tick(base_tick(2100, 200, 500));  // above max: release
    send_tick(base_tick(20, 200, 500));    // at the floor: stop, valve closed
    // severe overpressure needs three ticks in a row
    repeat (3) send_tick(base_tick(2200, 200, 500));
    send_tick(base_tick(100, 200, 500));   // auto clear to stop, motor waits
    // broken level sensor: low level check skipped
    t = base_tick(100, 200, 0);
    t.level_sensor_err = 1'b1;
    send_tick(t);
    // link lost hides the drive code and the mode check
    t = base_tick(100, 200, 500);
    t.motor_link_lost   = 1'b1;
    t.drive_error_code  = 16'hFFFF;
    t.mode_not_velocity = 1'b1;
    send_tick(t);
    // reset edge while the fault clears on its own
    t = base_tick(100, 200, 500);
    t.reset_request = 1'b1;
    send_tick(t);
    // hottest oil raises overheat after three ticks
    repeat (3) send_tick(base_tick(100, 2047, 500));
    // reset edge refused: level sits exactly at the limit
    t = base_tick(100, 100, 200);
    t.reset_request = 1'b1;
    send_tick(t);
    send_tick(base_tick(100, 100, 500));
    // reset edge outside the fault state, so no re-check runs
    t = base_tick(100, 100, 500);
    t.reset_request = 1'b1;
    send_tick(t);
    // setting hold with a sensor fault, then release to stop
    t = base_tick(100, 100, 500);
    t.setting_hold     = 1'b1;
    t.press_sensor_err = 1'b1;
    send_tick(t);
    send_tick(base_tick(100, 100, 500));
    // drive fault through the status word, mode not velocity
    t = base_tick(100, 100, 500);
    t.mode_not_velocity = 1'b1;
    t.drive_status_word = 16'h0008;
    send_tick(t);

    // random phases, each under its own set of limits
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_limits(0, 0, 0, 0, -2048, 0);
        1: set_limits(65535, 65535, 65535, 65535, 2047, 1023);
        2: set_limits(500, 2000, 30, 2200, 850, 200);
        3: set_limits(100, 1500, 400, 1700, 850, 200);     // band below zero
        4: set_limits(800, 3000, 0, 3000, 2000, 1000);
        5: set_limits(600, 2500, 50, 2800, -400, 0);
        default: begin
          n = $urandom_range(50, 3000);
          k = n + int'($urandom_range(0, 2000));
          set_limits(n, k, $urandom_range(0, 300), clip(k + int'($urandom_range(0, 600)), 0, 65535),
                     int'($urandom_range(0, 2400)) - 400, $urandom_range(0, 1000));
        end
      endcase
      walk_p = sh_target - sh_hyst - 10;

      // back-to-back ticks while the result side holds off
      if (ph == 2) begin
        hold_off_go = 1;
        repeat (24) send_tick(next_tick());
      end

      n = (ph < 2) ? 120 : 280;
      for (k = 0; k < n; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
        end
        burst_left--;
        send_tick(next_tick());
      end
    end

    // drain with a bound, then let the pipeline settle
    tick_ch.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hdl/ppfs_pkg.sv
hdl/ppfs_if.sv
hdl/pump_pressure_fault_supervisor_top.sv
hdl/ppfs_checker.sv
tb/sv/ppfs_result_checker.sv
tb/sv/tb_pump_pressure_fault_supervisor_top.sv
